@@ hw/rtl/ipv4_header_receive_filter_assert.svh @@
// Assertion macros shared by the IPv4 header receive filter RTL.
`ifndef IPV4_HEADER_RECEIVE_FILTER_ASSERT_SVH
`define IPV4_HEADER_RECEIVE_FILTER_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define IPV4HRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define IPV4HRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ipv4hrf_pkg.sv @@
// Types and constants of the IPv4 header receive filter.
package ipv4hrf_pkg;

  // Verdict codes
  typedef enum logic [1:0] {
    ST_DELIVERED  = 2'd0,
    ST_WRONG_DEST = 2'd1,
    ST_FRAGMENT   = 2'd2,
    ST_CSUM_FAIL  = 2'd3
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] REG_OWN_ADDR   = 2'd0;
  localparam logic [1:0] REG_BCAST_ADDR = 2'd1;
  localparam logic [1:0] REG_FRAG_ALLOW = 2'd2;

  localparam logic [31:0] BCAST_RESET = 32'hFFFF_FFFF;

  // Header byte positions
  localparam logic [5:0] BYTE_VER_IHL   = 6'd0;
  localparam logic [5:0] BYTE_TLEN_HI   = 6'd2;
  localparam logic [5:0] BYTE_TLEN_LO   = 6'd3;
  localparam logic [5:0] BYTE_FLAGS_OFF = 6'd6;
  localparam logic [5:0] BYTE_OFF_LO    = 6'd7;
  localparam logic [5:0] BYTE_TTL       = 6'd8;
  localparam logic [5:0] BYTE_PROTO     = 6'd9;
  localparam logic [5:0] BYTE_SRC0      = 6'd12;
  localparam logic [5:0] BYTE_SRC1      = 6'd13;
  localparam logic [5:0] BYTE_SRC2      = 6'd14;
  localparam logic [5:0] BYTE_SRC3      = 6'd15;
  localparam logic [5:0] BYTE_DST0      = 6'd16;
  localparam logic [5:0] BYTE_DST1      = 6'd17;
  localparam logic [5:0] BYTE_DST2      = 6'd18;
  localparam logic [5:0] BYTE_DST3      = 6'd19;

  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [6:0]  MIN_HDR_BYTES = 7'd20;
  localparam logic [5:0]  MAX_HDR_BYTES = 6'd60;
  localparam logic [2:0]  MF_ONLY       = 3'd1;
  localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;

endpackage

@@ hw/rtl/ipv4hrf_if.sv @@
// Handshake interfaces of the IPv4 header receive filter: byte input, verdict, config.
interface ipv4hrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_start;

  modport source (output valid, output data_byte, output packet_start, input ready);
  modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

interface ipv4hrf_res_if;
  import ipv4hrf_pkg::*;
  logic        valid;
  logic        ready;
  status_e     status;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [7:0]  protocol_number;
  logic [15:0] payload_length;
  logic [7:0]  ttl_out;

  modport source (output valid, output status, output source_address, output dest_address,
                  output protocol_number, output payload_length, output ttl_out,
                  input ready);
  modport sink   (input valid, input status, input source_address, input dest_address,
                  input protocol_number, input payload_length, input ttl_out,
                  output ready);
endinterface

interface ipv4hrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_idx;
  logic [31:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

@@ hw/rtl/ipv4_header_receive_filter.sv @@
// IPv4 header receive filter: byte-wide header capture, checksum and verdict.
//
//   channel | dir | payload                                          | accepted when
//   in_i    | in  | data_byte[7:0], packet_start                     | valid & ready
//   res_o   | out | status, source/dest_address, protocol_number,    | valid & ready
//           |     | payload_length, ttl_out                          |
//   cfg_i   | in  | reg_idx[1:0], wdata[31:0]                        | valid (ready tied 1)
//
// One byte per cycle while in_i.ready is high. The last header byte is taken into the input
// register and its verdict into the result register. The per-byte update of the 16-bit ones'
// complement sum and the field capture sit between those two registers.
// Reset is immediate: no clearing pass. A stalled verdict holds in the result register;
// the input register keeps taking bytes that yield no verdict, and backs up into
// in_i.ready only when a second verdict is ready while the first is still unread.
module ipv4_header_receive_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ipv4hrf_in_if.sink           in_i,
  ipv4hrf_res_if.source        res_o,
  ipv4hrf_cfg_if.sink          cfg_i
);
  import ipv4hrf_pkg::*;
  `include "ipv4_header_receive_filter_assert.svh"

  // Configuration registers
  logic [31:0] own_addr_q, bcast_addr_q;
  logic        frag_allow_q;

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;

  // Header collection state
  logic [5:0]  byte_cnt_q, byte_cnt_d;
  logic        hdr_done_q, hdr_done_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [2:0]  flags_q, flags_d;
  logic [12:0] frag_off_q, frag_off_d;
  logic [15:0] tot_len_q, tot_len_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  // Result register
  logic        res_valid_q, res_valid_d;
  status_e     res_status_q, status_c;
  logic [31:0] res_src_q, res_dst_q;
  logic [7:0]  res_proto_q, res_ttl_q, ttl_out_c;
  logic [15:0] res_len_q, payload_c;

  logic        in_fire, s1_go, s1_fire, active, hdr_end;
  logic [5:0]  idx;
  logic [15:0] sum_base;
  logic [16:0] sum_raw;
  logic [15:0] sum_fold;
  logic [6:0]  cnt_inc, end_len;
  logic [15:0] hlen;
  logic        dst_ok, is_frag, csum_bad;

  // Handshakes
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign s1_go       = !hdr_end || !res_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && s1_go;
  assign in_i.ready  = !s1_valid_q || s1_go;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= '0;
      bcast_addr_q <= BCAST_RESET;
      frag_allow_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_idx)
        REG_OWN_ADDR:   own_addr_q   <= cfg_i.wdata;
        REG_BCAST_ADDR: bcast_addr_q <= cfg_i.wdata;
        REG_FRAG_ALLOW: frag_allow_q <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= in_i.data_byte;
      s1_start_q <= in_i.packet_start;
    end
  end

  // Per-byte capture and checksum accumulate
  always_comb begin
    active   = s1_valid_q && (s1_start_q || !hdr_done_q);
    idx      = s1_start_q ? '0 : byte_cnt_q;
    sum_base = s1_start_q ? '0 : sum_q;

    ihl_d      = ihl_q;
    tot_len_d  = tot_len_q;
    flags_d    = flags_q;
    frag_off_d = frag_off_q;
    ttl_d      = ttl_q;
    proto_d    = proto_q;
    src_d      = src_q;
    dst_d      = dst_q;
    case (idx)
      BYTE_VER_IHL:   ihl_d = s1_byte_q[3:0];
      BYTE_TLEN_HI:   tot_len_d = {s1_byte_q, tot_len_q[7:0]};
      BYTE_TLEN_LO:   tot_len_d = {tot_len_q[15:8], s1_byte_q};
      BYTE_FLAGS_OFF: begin
        flags_d    = s1_byte_q[7:5];
        frag_off_d = {s1_byte_q[4:0], frag_off_q[7:0]};
      end
      BYTE_OFF_LO:    frag_off_d = {frag_off_q[12:8], s1_byte_q};
      BYTE_TTL:       ttl_d = s1_byte_q;
      BYTE_PROTO:     proto_d = s1_byte_q;
      BYTE_SRC0, BYTE_SRC1, BYTE_SRC2, BYTE_SRC3: src_d = {src_q[23:0], s1_byte_q};
      BYTE_DST0, BYTE_DST1, BYTE_DST2, BYTE_DST3: dst_d = {dst_q[23:0], s1_byte_q};
      default: ;
    endcase

    // Even byte waits as the high half; odd byte completes the word, end-around carry
    sum_raw  = {1'b0, sum_base} + {1'b0, pend_q, s1_byte_q};
    sum_fold = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];
    if (idx[0]) begin
      pend_d = pend_q;
      sum_d  = sum_fold;
    end else begin
      pend_d = s1_byte_q;
      sum_d  = sum_base;
    end

    cnt_inc    = {1'b0, idx} + 7'd1;
    byte_cnt_d = cnt_inc[5:0];
    end_len    = (ihl_d < MIN_IHL) ? MIN_HDR_BYTES : {1'b0, ihl_d, 2'b00};
    hdr_end    = active && !(cnt_inc < end_len);
    hdr_done_d = hdr_end;
  end

  // Verdict on the last header byte
  always_comb begin
    hlen     = {10'd0, ihl_d, 2'b00};
    dst_ok   = (own_addr_q == '0) || (dst_d == own_addr_q) || (dst_d == bcast_addr_q);
    is_frag  = !frag_allow_q && ((flags_d == MF_ONLY) || (frag_off_d != '0));
    csum_bad = (ihl_d < MIN_IHL) || (sum_d != CSUM_GOOD);
    ttl_out_c = ttl_d;
    if (!dst_ok) begin
      status_c = ST_WRONG_DEST;
    end else if (is_frag) begin
      status_c = ST_FRAGMENT;
    end else if (csum_bad) begin
      status_c = ST_CSUM_FAIL;
    end else begin
      status_c = ST_DELIVERED;
      if (ttl_d != '0) begin
        ttl_out_c = ttl_d - 8'd1;
      end
    end
    payload_c = (tot_len_d > hlen) ? (tot_len_d - hlen) : '0;
  end

  // Header state: advance only on bytes that belong to a header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      hdr_done_q <= 1'b1;
      sum_q      <= '0;
      pend_q     <= '0;
      ihl_q      <= '0;
      flags_q    <= '0;
      frag_off_q <= '0;
      tot_len_q  <= '0;
      ttl_q      <= '0;
      proto_q    <= '0;
      src_q      <= '0;
      dst_q      <= '0;
    end else if (s1_fire && active) begin
      byte_cnt_q <= byte_cnt_d;
      hdr_done_q <= hdr_done_d;
      sum_q      <= sum_d;
      pend_q     <= pend_d;
      ihl_q      <= ihl_d;
      flags_q    <= flags_d;
      frag_off_q <= frag_off_d;
      tot_len_q  <= tot_len_d;
      ttl_q      <= ttl_d;
      proto_q    <= proto_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
    end
  end

  // Result register
  always_comb begin
    res_valid_d = res_valid_q;
    if (s1_fire && hdr_end) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && hdr_end) begin
      res_status_q <= status_c;
      res_src_q    <= src_d;
      res_dst_q    <= dst_d;
      res_proto_q  <= proto_d;
      res_len_q    <= payload_c;
      res_ttl_q    <= ttl_out_c;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.status          = res_status_q;
  assign res_o.source_address  = res_src_q;
  assign res_o.dest_address    = res_dst_q;
  assign res_o.protocol_number = res_proto_q;
  assign res_o.payload_length  = res_len_q;
  assign res_o.ttl_out         = res_ttl_q;

  // Checks
  `IPV4HRF_ASSERT_NOW(a_no_overwrite, s1_fire && hdr_end, !res_valid_q || res_o.ready, "verdict overwrote an unread verdict")
  `IPV4HRF_ASSERT_NEXT(a_done_after_verdict, s1_fire && hdr_end, hdr_done_q && res_valid_q, "header not closed after verdict")
  `IPV4HRF_ASSERT_NOW(a_cnt_in_range, !hdr_done_q, byte_cnt_q < MAX_HDR_BYTES, "byte count past longest header")
  `IPV4HRF_ASSERT_NOW(a_idle_no_verdict, s1_valid_q && !s1_start_q && hdr_done_q, !hdr_end, "verdict from a byte outside a header")

endmodule
